// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with an explicit clock and active-low reset
`define KDBT_ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// assertion on the default clk and arst_n of the enclosing module
`define KDBT_ASSERT(lbl, prop, msg) \
	`KDBT_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// ===== design/kdbt_pkg.sv =====
// shared types and constants of the keyed denial backoff table
package kdbt_pkg;

	localparam int KEY_W    = 32;
	localparam int TIME_W   = 32;
	localparam int END_W    = 33;
	localparam int CNT_W    = 8;
	localparam int REMAIN_W = 16;
	localparam int SCHED_W  = 16;
	localparam int SCHED_LEN = 6;
	localparam int ADDR_W   = 3;
	localparam int SEL_W    = 3;

	localparam logic [CNT_W-1:0]    COUNT_MAX  = 8'd255;
	localparam logic [REMAIN_W-1:0] REMAIN_MAX = 16'hFFFF;

	// configuration register indexes
	localparam logic [ADDR_W-1:0] REG_AFTER_ONE      = 3'd0;
	localparam logic [ADDR_W-1:0] REG_AFTER_TWO      = 3'd1;
	localparam logic [ADDR_W-1:0] REG_AFTER_THREE    = 3'd2;
	localparam logic [ADDR_W-1:0] REG_AFTER_FOUR     = 3'd3;
	localparam logic [ADDR_W-1:0] REG_AFTER_FIVE     = 3'd4;
	localparam logic [ADDR_W-1:0] REG_AFTER_SIX_PLUS = 3'd5;

	localparam logic [SEL_W-1:0] SEL_LAST = 3'd5;

	localparam logic [SCHED_W-1:0] RST_AFTER_ONE      = 16'd0;
	localparam logic [SCHED_W-1:0] RST_AFTER_TWO      = 16'd0;
	localparam logic [SCHED_W-1:0] RST_AFTER_THREE    = 16'd5;
	localparam logic [SCHED_W-1:0] RST_AFTER_FOUR     = 16'd15;
	localparam logic [SCHED_W-1:0] RST_AFTER_FIVE     = 16'd60;
	localparam logic [SCHED_W-1:0] RST_AFTER_SIX_PLUS = 16'd300;

	typedef enum logic [1:0] {
		ACT_DENY  = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef logic [SCHED_LEN-1:0][SCHED_W-1:0] sched_t;

	// request token walking down the row of cells
	typedef struct packed {
		logic                vld;
		action_t             action;
		logic [KEY_W-1:0]    key;
		logic [TIME_W-1:0]   now;
		logic                hit;
		logic                created;
		logic                blocked;
		logic [REMAIN_W-1:0] remain;
	} token_t;

endpackage

// ===== design/kdbt_if.sv =====
// channel interfaces: command, response and configuration write
interface kdbt_cmd_if;
	import kdbt_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [KEY_W-1:0]  key_id;
	logic [TIME_W-1:0] now_seconds;
	modport source (output valid, action, key_id, now_seconds, input ready);
	modport sink (input valid, action, key_id, now_seconds, output ready);
endinterface

interface kdbt_rsp_if;
	import kdbt_pkg::*;
	logic                valid;
	logic                ready;
	logic                found;
	logic                dropped;
	logic                blocked;
	logic [REMAIN_W-1:0] remaining_seconds;
	modport source (output valid, found, dropped, blocked, remaining_seconds, input ready);
	modport sink (input valid, found, dropped, blocked, remaining_seconds, output ready);
endinterface

interface kdbt_cfg_if;
	import kdbt_pkg::*;
	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  addr;
	logic [SCHED_W-1:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// ===== design/keyed_denial_backoff_table.sv =====
// top level of the keyed denial backoff table
// A command beat (record denial, reset key or query) enters a row of TABLE_DEPTH entry cells
// and walks one cell per clock while the row is not held; each cell compares the key against
// the entry it holds and updates it in place on a denial or reset. One command is in flight
// at a time: the response is registered after the token leaves the last cell, and a new
// command is taken the cycle after the response is captured, so the command rate is set by
// the walk through the row. The response register lets the next command start while a
// response still waits; the row stalls only if a second response would overwrite it.
// Denials for new keys fill entries in order; once all are used such denials are dropped.
module keyed_denial_backoff_table import kdbt_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	kdbt_cfg_if.sink     cfg,
	kdbt_cmd_if.sink     cmd,
	kdbt_rsp_if.source   rsp
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	sched_t        sched_q;
	logic [CW-1:0] used_q;
	logic          busy_q;
	logic          out_valid_q;
	logic          out_found_q, out_dropped_q, out_blocked_q;
	logic [REMAIN_W-1:0] out_remain_q;

	token_t tok [0:TABLE_DEPTH];
	token_t tok_last;
	logic   adv, load;

	assign cfg.ready = 1'b1;
	assign cmd.ready = !busy_q;

	always_comb begin
		tok[0]         = '0;
		tok[0].vld     = cmd.valid && !busy_q;
		tok[0].action  = action_t'(cmd.action);
		tok[0].key     = cmd.key_id;
		tok[0].now     = cmd.now_seconds;
	end

	assign tok_last = tok[TABLE_DEPTH];
	// hold the row while a finished token cannot enter the response register
	assign adv  = !(tok_last.vld && out_valid_q && !rsp.ready);
	assign load = tok_last.vld && adv;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		kdbt_cell #(
			.INDEX (i),
			.CW    (CW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.used    (used_q),
			.sched   (sched_q),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_q[REG_AFTER_ONE]      <= RST_AFTER_ONE;
			sched_q[REG_AFTER_TWO]      <= RST_AFTER_TWO;
			sched_q[REG_AFTER_THREE]    <= RST_AFTER_THREE;
			sched_q[REG_AFTER_FOUR]     <= RST_AFTER_FOUR;
			sched_q[REG_AFTER_FIVE]     <= RST_AFTER_FIVE;
			sched_q[REG_AFTER_SIX_PLUS] <= RST_AFTER_SIX_PLUS;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				REG_AFTER_ONE:      sched_q[REG_AFTER_ONE]      <= cfg.data;
				REG_AFTER_TWO:      sched_q[REG_AFTER_TWO]      <= cfg.data;
				REG_AFTER_THREE:    sched_q[REG_AFTER_THREE]    <= cfg.data;
				REG_AFTER_FOUR:     sched_q[REG_AFTER_FOUR]     <= cfg.data;
				REG_AFTER_FIVE:     sched_q[REG_AFTER_FIVE]     <= cfg.data;
				REG_AFTER_SIX_PLUS: sched_q[REG_AFTER_SIX_PLUS] <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load && tok_last.created) begin
				used_q <= used_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_found_q   <= tok_last.hit;
			out_dropped_q <= (tok_last.action == ACT_DENY) && !tok_last.hit;
			out_blocked_q <= tok_last.blocked;
			out_remain_q  <= tok_last.remain;
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.found             = out_found_q;
	assign rsp.dropped           = out_dropped_q;
	assign rsp.blocked           = out_blocked_q;
	assign rsp.remaining_seconds = out_remain_q;

endmodule

// ===== design/kdbt_cell.sv =====
// one table entry: holds a key, its denial count and backoff end, and serves the passing token
module kdbt_cell import kdbt_pkg::*; #(
	parameter int INDEX = 0,
	parameter int CW    = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic [CW-1:0] used,
	input  sched_t        sched,
	input  token_t        tok_in,
	output token_t        tok_out
);

	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] cnt_q;
	logic [END_W-1:0] end_q;

	logic               occupied, free_slot, match, live, wr_en;
	logic [CNT_W-1:0]   cnt_base, cnt_new;
	logic [SEL_W-1:0]   sel;
	logic [SCHED_W-1:0] wait_s;
	logic [END_W-1:0]   now_ext, end_sum, diff;
	logic [KEY_W-1:0]   key_d;
	logic [CNT_W-1:0]   cnt_d;
	logic [END_W-1:0]   end_d;
	token_t             tok_d;

	assign occupied  = CW'(INDEX) < used;
	assign free_slot = CW'(INDEX) == used;
	assign match     = occupied && (key_q == tok_in.key);
	assign live      = tok_in.vld && !tok_in.hit;

	// a new entry starts from a zero count
	assign cnt_base = match ? cnt_q : '0;
	assign cnt_new  = (cnt_base == COUNT_MAX) ? COUNT_MAX : cnt_base + 1'b1;
	assign sel      = (cnt_new > CNT_W'(SCHED_LEN)) ? SEL_LAST : SEL_W'(cnt_new - 1'b1);
	assign wait_s   = sched[sel];
	assign now_ext  = {1'b0, tok_in.now};
	assign end_sum  = now_ext + {{(END_W-SCHED_W){1'b0}}, wait_s};
	assign diff     = end_q - now_ext;

	always_comb begin
		tok_d = tok_in;
		wr_en = 1'b0;
		key_d = key_q;
		cnt_d = cnt_q;
		end_d = end_q;
		if (live) begin
			unique case (tok_in.action)
				ACT_DENY: begin
					if (match || free_slot) begin
						tok_d.hit     = 1'b1;
						tok_d.created = !match;
						tok_d.remain  = wait_s;
						wr_en = 1'b1;
						key_d = tok_in.key;
						cnt_d = cnt_new;
						end_d = end_sum;
					end
				end
				ACT_CLEAR: begin
					if (match) begin
						tok_d.hit = 1'b1;
						wr_en = 1'b1;
						cnt_d = '0;
						end_d = '0;
					end
				end
				ACT_QUERY: begin
					if (match) begin
						tok_d.hit = 1'b1;
						if (end_q > now_ext) begin
							tok_d.blocked = 1'b1;
							tok_d.remain  = (diff > {{(END_W-REMAIN_W){1'b0}}, REMAIN_MAX})
								? REMAIN_MAX : diff[REMAIN_W-1:0];
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv && wr_en) begin
			key_q <= key_d;
			cnt_q <= cnt_d;
			end_q <= end_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else if (adv) begin
			tok_out <= tok_d;
		end
	end

endmodule

// ===== design/kdbt_checker.sv =====
// port-level checker for the keyed denial backoff table, bound to the top level
`include "assert_macros.svh"

module kdbt_checker import kdbt_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic                found,
	input logic                dropped,
	input logic                blocked,
	input logic [REMAIN_W-1:0] remaining_seconds
);

	// one command in flight: after a command beat nothing more is taken next cycle
	`KDBT_ASSERT(a_one_in_flight, cmd_valid && cmd_ready |=> !cmd_ready, "second command taken while busy")

	// a dropped denial never reports a table entry
	`KDBT_ASSERT(a_drop_not_found, rsp_valid && dropped |-> !found && !blocked && remaining_seconds == '0, "dropped response carries entry data")

	// a blocked key is a known key with time still to wait
	`KDBT_ASSERT(a_blocked_found, rsp_valid && blocked |-> found && remaining_seconds != '0, "blocked response without entry or wait")

	// a stalled response beat holds
	`KDBT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(found) && $stable(dropped) && $stable(blocked) && $stable(remaining_seconds), "stalled response changed")

endmodule

bind keyed_denial_backoff_table kdbt_checker u_kdbt_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.cmd_valid         (cmd.valid),
	.cmd_ready         (cmd.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.found             (rsp.found),
	.dropped           (rsp.dropped),
	.blocked           (rsp.blocked),
	.remaining_seconds (rsp.remaining_seconds)
);
